/* sv/lts_pkg.sv */
// Package for the lexical token scanner: token kinds, token and token-pair types,
// character codes and the small character-class helpers.
// No dependencies; used by every other file of the block.
package lts_pkg;

  typedef enum logic [4:0] {
    K_DIV     = 5'd0,
    K_MULT    = 5'd1,
    K_MINUS   = 5'd2,
    K_PLUS    = 5'd3,
    K_NEWLINE = 5'd4,
    K_NUM     = 5'd5,
    K_STRING  = 5'd6,
    K_ID      = 5'd7,
    K_NOT     = 5'd8,
    K_NEQ     = 5'd9,
    K_GT      = 5'd10,
    K_GTE     = 5'd11,
    K_LT      = 5'd12,
    K_LTE     = 5'd13,
    K_ATTR    = 5'd14,
    K_EQ      = 5'd15,
    K_OR      = 5'd16,
    K_AND     = 5'd17,
    K_RPAR    = 5'd18,
    K_LPAR    = 5'd19,
    K_MOD     = 5'd20,
    K_EOF     = 5'd21,
    K_ERROR   = 5'd22
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  // Tokens produced by one accepted byte; tok0 goes out first.
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } tok_pair_t;

  localparam logic [7:0] CH_EOF   = 8'hFF;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  localparam int unsigned QUEUE_DEPTH = 4;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
           b == CH_PCT || b == CH_LPAR || b == CH_RPAR || b == CH_AMP || b == CH_BAR;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_MULT;
      CH_SLASH: k = K_DIV;
      CH_PCT:   k = K_MOD;
      CH_LPAR:  k = K_LPAR;
      CH_RPAR:  k = K_RPAR;
      CH_AMP:   k = K_AND;
      CH_BAR:   k = K_OR;
      default:  k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

/* sv/lts_scan.sv */
// Lexer automaton: scan state, comment flag, line and column counters and the
// current lexeme. Depends on lts_pkg; yields the tokens caused by the byte accepted.
module lts_scan #(
  parameter int MAX_LEXEME = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  output lts_pkg::tok_pair_t tokens
);

  localparam int LW = $clog2(MAX_LEXEME + 1);

  typedef enum logic [3:0] {
    S_START = 4'd0,
    S_EQ    = 4'd1,
    S_LT    = 4'd2,
    S_GT    = 4'd3,
    S_NOT   = 4'd4,
    S_ID    = 4'd5,
    S_STR   = 4'd6,
    S_INT   = 4'd8,
    S_DOT   = 4'd9,
    S_FRAC  = 4'd10
  } state_t;

  state_t          st_r, st_nxt;
  logic            cmt_r, cmt_nxt;
  logic [15:0]     line_r, line_nxt;
  logic [15:0]     col_r, col_nxt;
  logic [15:0]     scol_r, scol_nxt;
  logic [LW-1:0]   len_r, len_nxt;

  logic            ta_v, tb_v, rescan;
  lts_pkg::kind_t  ta_kind, tb_kind;
  logic [7:0]      ta_len;
  logic [15:0]     col_mid;
  lts_pkg::tok_t   tok_a, tok_b;
  logic [1:0]      n_tok;

  function automatic logic [LW-1:0] len_inc(input logic [LW-1:0] v);
    return (32'(v) < 32'(MAX_LEXEME)) ? v + LW'(1) : v;
  endfunction

  function automatic logic [7:0] len_out(input logic [LW-1:0] v);
    return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
  endfunction

  function automatic lts_pkg::kind_t one_kind(input state_t s);
    lts_pkg::kind_t k;
    case (s)
      S_EQ:    k = lts_pkg::K_ATTR;
      S_LT:    k = lts_pkg::K_LT;
      S_GT:    k = lts_pkg::K_GT;
      default: k = lts_pkg::K_NOT;
    endcase
    return k;
  endfunction

  function automatic lts_pkg::kind_t two_kind(input state_t s);
    lts_pkg::kind_t k;
    case (s)
      S_EQ:    k = lts_pkg::K_EQ;
      S_LT:    k = lts_pkg::K_LTE;
      S_GT:    k = lts_pkg::K_GTE;
      default: k = lts_pkg::K_NEQ;
    endcase
    return k;
  endfunction

  always_comb begin
    st_nxt   = st_r;
    cmt_nxt  = cmt_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    scol_nxt = scol_r;
    len_nxt  = len_r;
    ta_v     = 1'b0;
    ta_kind  = lts_pkg::K_ERROR;
    tb_v     = 1'b0;
    tb_kind  = lts_pkg::K_ERROR;
    rescan   = 1'b0;

    // First, a byte that arrives inside a token.
    case (st_r)
      S_EQ, S_LT, S_GT, S_NOT: begin
        st_nxt = S_START;
        ta_v   = 1'b1;
        if (in_byte == lts_pkg::CH_EQ) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
          ta_kind = two_kind(st_r);
        end else begin
          ta_kind = one_kind(st_r);
          rescan  = 1'b1;
        end
      end
      S_ID: begin
        if (lts_pkg::is_letter(in_byte) || lts_pkg::is_digit(in_byte)) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
        end else begin
          st_nxt  = S_START;
          ta_v    = 1'b1;
          ta_kind = lts_pkg::K_ID;
          rescan  = 1'b1;
        end
      end
      S_STR: begin
        if (in_byte == lts_pkg::CH_EOF) begin
          st_nxt  = S_START;
          ta_v    = 1'b1;
          ta_kind = lts_pkg::K_ERROR;
          rescan  = 1'b1;
        end else begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
          if (in_byte == lts_pkg::CH_QUOTE) begin
            st_nxt  = S_START;
            ta_v    = 1'b1;
            ta_kind = lts_pkg::K_STRING;
          end
        end
      end
      S_INT: begin
        if (lts_pkg::is_digit(in_byte)) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
        end else if (in_byte == lts_pkg::CH_DOT) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
          st_nxt  = S_DOT;
        end else begin
          st_nxt  = S_START;
          ta_v    = 1'b1;
          ta_kind = lts_pkg::K_NUM;
          rescan  = 1'b1;
        end
      end
      S_DOT: begin
        if (lts_pkg::is_digit(in_byte)) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
          st_nxt  = S_FRAC;
        end else begin
          st_nxt  = S_START;
          ta_v    = 1'b1;
          ta_kind = lts_pkg::K_ERROR;
          if (in_byte == lts_pkg::CH_NL || in_byte == lts_pkg::CH_EOF) begin
            rescan = 1'b1;
          end else begin
            len_nxt = len_inc(len_r);
            col_nxt = lts_pkg::sat_inc16(col_r);
          end
        end
      end
      S_FRAC: begin
        if (lts_pkg::is_digit(in_byte)) begin
          len_nxt = len_inc(len_r);
          col_nxt = lts_pkg::sat_inc16(col_r);
        end else begin
          st_nxt  = S_START;
          ta_v    = 1'b1;
          ta_kind = lts_pkg::K_NUM;
          rescan  = 1'b1;
        end
      end
      default: begin
        st_nxt = S_START;
        rescan = 1'b1;
      end
    endcase

    ta_len  = len_out(len_nxt);
    col_mid = col_nxt;

    // Then the byte seen from the start state, if it still has to be scanned.
    if (rescan) begin
      if (cmt_r) begin
        if (in_byte == lts_pkg::CH_NL) begin
          cmt_nxt  = 1'b0;
          line_nxt = lts_pkg::sat_inc16(line_r);
          col_nxt  = 16'd0;
        end else if (in_byte == lts_pkg::CH_EOF) begin
          cmt_nxt = 1'b0;
          tb_v    = 1'b1;
          tb_kind = lts_pkg::K_EOF;
        end else begin
          col_nxt = lts_pkg::sat_inc16(col_mid);
        end
      end else if (in_byte == lts_pkg::CH_SP || in_byte == lts_pkg::CH_TAB) begin
        col_nxt = lts_pkg::sat_inc16(col_mid);
      end else if (in_byte == lts_pkg::CH_HASH) begin
        cmt_nxt = 1'b1;
        col_nxt = lts_pkg::sat_inc16(col_mid);
      end else if (in_byte == lts_pkg::CH_NL) begin
        tb_v     = 1'b1;
        tb_kind  = lts_pkg::K_NEWLINE;
        line_nxt = lts_pkg::sat_inc16(line_r);
        col_nxt  = 16'd0;
      end else if (lts_pkg::is_single(in_byte)) begin
        tb_v    = 1'b1;
        tb_kind = lts_pkg::single_kind(in_byte);
        col_nxt = lts_pkg::sat_inc16(col_mid);
      end else if (in_byte == lts_pkg::CH_EQ || in_byte == lts_pkg::CH_LT ||
                   in_byte == lts_pkg::CH_GT || in_byte == lts_pkg::CH_BANG ||
                   in_byte == lts_pkg::CH_QUOTE || in_byte == lts_pkg::CH_DOT ||
                   lts_pkg::is_letter(in_byte) || lts_pkg::is_digit(in_byte)) begin
        scol_nxt = col_mid;
        len_nxt  = LW'(1);
        col_nxt  = lts_pkg::sat_inc16(col_mid);
        if (in_byte == lts_pkg::CH_EQ) begin
          st_nxt = S_EQ;
        end else if (in_byte == lts_pkg::CH_LT) begin
          st_nxt = S_LT;
        end else if (in_byte == lts_pkg::CH_GT) begin
          st_nxt = S_GT;
        end else if (in_byte == lts_pkg::CH_BANG) begin
          st_nxt = S_NOT;
        end else if (in_byte == lts_pkg::CH_QUOTE) begin
          st_nxt = S_STR;
        end else if (in_byte == lts_pkg::CH_DOT) begin
          st_nxt = S_DOT;
        end else if (lts_pkg::is_letter(in_byte)) begin
          st_nxt = S_ID;
        end else begin
          st_nxt = S_INT;
        end
      end else if (in_byte == lts_pkg::CH_EOF) begin
        tb_v    = 1'b1;
        tb_kind = lts_pkg::K_EOF;
      end else begin
        tb_v    = 1'b1;
        tb_kind = lts_pkg::K_ERROR;
        col_nxt = lts_pkg::sat_inc16(col_mid);
      end
    end
  end

  always_comb begin
    n_tok = {1'b0, ta_v} + {1'b0, tb_v};

    tok_a.kind   = ta_kind;
    tok_a.line   = line_r;
    tok_a.column = scol_r;
    tok_a.length = ta_len;
    tok_a.last   = !tb_v;

    tok_b.kind   = tb_kind;
    tok_b.line   = line_r;
    tok_b.column = col_mid;
    tok_b.length = 8'd1;
    tok_b.last   = 1'b1;

    tokens.count = in_fire ? n_tok : 2'd0;
    tokens.tok0  = ta_v ? tok_a : tok_b;
    tokens.tok1  = tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_START;
      cmt_r  <= 1'b0;
      line_r <= 16'd1;
      col_r  <= 16'd0;
      scol_r <= 16'd0;
      len_r  <= '0;
    end else if (in_fire) begin
      st_r   <= st_nxt;
      cmt_r  <= cmt_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      scol_r <= scol_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

/* sv/lts_tokq.sv */
// Four-entry token queue between the scanner and the result channel; takes up to two tokens
// a cycle while space_ok is high and gives one a cycle while out_ready is high. Depends on lts_pkg.
module lts_tokq (
  input  logic               clk,
  input  logic               rst_n,
  input  lts_pkg::tok_pair_t push,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output lts_pkg::tok_t      out_tok
);

  localparam int PW = $clog2(lts_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(lts_pkg::QUEUE_DEPTH + 1);

  lts_pkg::tok_t  entry_r [lts_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_tok   = entry_r[rd_r];
  assign space_ok  = 32'(cnt_r) <= lts_pkg::QUEUE_DEPTH - 2;

  always_comb begin
    wr_nxt  = wr_r + PW'(push.count);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_r] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_r + PW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/lexical_token_scanner.sv */
// Top level of the lexical token scanner: stream ports, scanner and token queue.
// Depends on lts_pkg, lts_scan and lts_tokq.
//
// The block takes one source byte per cycle while in_tready is high and reports one beat
// per token, with kind, line, start column and length; the byte 0xFF marks the end of
// input and gives an eof token. Spaces, tabs and comments from '#' to the next newline
// give no beat. Every byte goes through the automaton in the cycle it is taken; a byte
// that both ends one token and forms another yields two beats, and the result side
// drains one beat per cycle while out_tready is high through a four-entry token queue.
// in_tready drops while the queue holds more than two tokens, so the stream runs at one
// byte per cycle as long as the result side keeps up.
module lexical_token_scanner #(
  parameter int MAX_LEXEME = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte [7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // token_kind [4:0], token_line [20:5],
                                  // token_column [36:21], token_length [44:37], zeros
  output logic        out_tlast   // last_of_run
);

  lts_pkg::tok_pair_t tokens;
  lts_pkg::tok_t      head;
  logic               in_fire;

  assign in_fire = in_tvalid && in_tready;

  lts_scan #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .tokens  (tokens)
  );

  lts_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tokens),
    .space_ok  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  assign out_tdata = {3'b000, head.length, head.column, head.line, head.kind};
  assign out_tlast = head.last;

endmodule

/* sv/lts_checker.sv */
// Port-level checks for the lexical token scanner, bound to the top level.
// Depends on the ports of lexical_token_scanner and on lts_pkg for codes.
module lts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= lts_pkg::K_ERROR)
    else $error("token kind out of range");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:5] != 16'd0)
    else $error("token line is zero");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[44:37] != 8'd0 && out_tdata[47:45] == 3'd0)
    else $error("token length is zero or padding is set");

  a_eof_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == lts_pkg::CH_EOF |=> out_tvalid)
    else $error("end marker gave no beat");

endmodule

bind lexical_token_scanner lts_checker u_lts_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for lexical_token_scanner: byte streams in, token beats out.
// A scoreboard class predicts each token from the accepted bytes and checks every beat.
// Depends on lts_pkg and the lexical_token_scanner RTL.
module tb_top;

  localparam int unsigned LEXEME_CAP  = 255;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LONG_STR    = 260;

  localparam logic [7:0] OP_CHARS [13] = '{lts_pkg::CH_PLUS, lts_pkg::CH_MINUS,
                                           lts_pkg::CH_STAR, lts_pkg::CH_SLASH,
                                           lts_pkg::CH_PCT, lts_pkg::CH_LPAR,
                                           lts_pkg::CH_RPAR, lts_pkg::CH_AMP,
                                           lts_pkg::CH_BAR, lts_pkg::CH_EQ,
                                           lts_pkg::CH_LT, lts_pkg::CH_GT,
                                           lts_pkg::CH_BANG};

  typedef enum logic [3:0] {
    SC_START   = 4'd0,
    SC_ASSIGN  = 4'd1,
    SC_LESS    = 4'd2,
    SC_GREATER = 4'd3,
    SC_BANG    = 4'd4,
    SC_IDENT   = 4'd5,
    SC_QUOTED  = 4'd6,
    SC_INT     = 4'd8,
    SC_DOT     = 4'd9,
    SC_FRAC    = 4'd10
  } scan_mode_t;

  class token_scoreboard;
    scan_mode_t     mode;
    bit             comment;
    int unsigned    line_no;
    int unsigned    col_no;
    int unsigned    tok_col;
    int unsigned    tok_len;
    int unsigned    n_errors;
    lts_pkg::tok_t  fresh_q[$];
    lts_pkg::tok_t  want_q[$];

    function new();
      mode     = SC_START;
      comment  = 1'b0;
      line_no  = 1;
      col_no   = 0;
      tok_col  = 0;
      tok_len  = 0;
      n_errors = 0;
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function bit is_num(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
    endfunction

    function void bump_col();
      if (col_no < 65535) col_no++;
    endfunction

    function void bump_line();
      if (line_no < 65535) line_no++;
    endfunction

    function void extend();
      if (tok_len < LEXEME_CAP) tok_len++;
      bump_col();
    endfunction

    function void open_token(scan_mode_t m);
      tok_col = col_no;
      tok_len = 1;
      mode    = m;
      bump_col();
    endfunction

    function void emit(lts_pkg::kind_t k, int unsigned c, int unsigned n);
      lts_pkg::tok_t t;
      t.kind   = k;
      t.line   = line_no[15:0];
      t.column = c[15:0];
      t.length = (n > 255) ? 8'hFF : n[7:0];
      t.last   = 1'b0;
      if (fresh_q.size() < 2) fresh_q.push_back(t);
    endfunction

    function bit op_char(logic [7:0] b, output lts_pkg::kind_t k);
      k = lts_pkg::K_ERROR;
      case (b)
        lts_pkg::CH_PLUS:  k = lts_pkg::K_PLUS;
        lts_pkg::CH_MINUS: k = lts_pkg::K_MINUS;
        lts_pkg::CH_STAR:  k = lts_pkg::K_MULT;
        lts_pkg::CH_SLASH: k = lts_pkg::K_DIV;
        lts_pkg::CH_PCT:   k = lts_pkg::K_MOD;
        lts_pkg::CH_LPAR:  k = lts_pkg::K_LPAR;
        lts_pkg::CH_RPAR:  k = lts_pkg::K_RPAR;
        lts_pkg::CH_AMP:   k = lts_pkg::K_AND;
        lts_pkg::CH_BAR:   k = lts_pkg::K_OR;
        default:           return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function lts_pkg::kind_t relop_kind(scan_mode_t m, bit with_eq);
      case (m)
        SC_ASSIGN:  return with_eq ? lts_pkg::K_EQ : lts_pkg::K_ATTR;
        SC_LESS:    return with_eq ? lts_pkg::K_LTE : lts_pkg::K_LT;
        SC_GREATER: return with_eq ? lts_pkg::K_GTE : lts_pkg::K_GT;
        default:    return with_eq ? lts_pkg::K_NEQ : lts_pkg::K_NOT;
      endcase
    endfunction

    function void scan_fresh(logic [7:0] b);
      lts_pkg::kind_t k;
      mode = SC_START;
      if (comment) begin
        if (b == lts_pkg::CH_NL) begin
          comment = 1'b0;
          bump_line();
          col_no = 0;
        end else if (b == lts_pkg::CH_EOF) begin
          comment = 1'b0;
          emit(lts_pkg::K_EOF, col_no, 1);
        end else begin
          bump_col();
        end
      end else if (b == lts_pkg::CH_SP || b == lts_pkg::CH_TAB) begin
        bump_col();
      end else if (b == lts_pkg::CH_HASH) begin
        comment = 1'b1;
        bump_col();
      end else if (b == lts_pkg::CH_NL) begin
        emit(lts_pkg::K_NEWLINE, col_no, 1);
        bump_line();
        col_no = 0;
      end else if (op_char(b, k)) begin
        emit(k, col_no, 1);
        bump_col();
      end else if (b == lts_pkg::CH_EQ) begin
        open_token(SC_ASSIGN);
      end else if (b == lts_pkg::CH_LT) begin
        open_token(SC_LESS);
      end else if (b == lts_pkg::CH_GT) begin
        open_token(SC_GREATER);
      end else if (b == lts_pkg::CH_BANG) begin
        open_token(SC_BANG);
      end else if (is_alpha(b)) begin
        open_token(SC_IDENT);
      end else if (b == lts_pkg::CH_QUOTE) begin
        open_token(SC_QUOTED);
      end else if (is_num(b)) begin
        open_token(SC_INT);
      end else if (b == lts_pkg::CH_DOT) begin
        open_token(SC_DOT);
      end else if (b == lts_pkg::CH_EOF) begin
        emit(lts_pkg::K_EOF, col_no, 1);
      end else begin
        emit(lts_pkg::K_ERROR, col_no, 1);
        bump_col();
      end
    endfunction

    // Returns 1 when the byte does not belong to the open token and must be scanned afresh.
    function bit scan_inside(logic [7:0] b);
      scan_mode_t held;
      held = mode;
      case (held)
        SC_ASSIGN, SC_LESS, SC_GREATER, SC_BANG: begin
          mode = SC_START;
          if (b == lts_pkg::CH_EQ) begin
            extend();
            emit(relop_kind(held, 1'b1), tok_col, tok_len);
            return 1'b0;
          end
          emit(relop_kind(held, 1'b0), tok_col, tok_len);
          return 1'b1;
        end
        SC_IDENT: begin
          if (is_alpha(b) || is_num(b)) begin
            extend();
            return 1'b0;
          end
          mode = SC_START;
          emit(lts_pkg::K_ID, tok_col, tok_len);
          return 1'b1;
        end
        SC_QUOTED: begin
          if (b == lts_pkg::CH_EOF) begin
            mode = SC_START;
            emit(lts_pkg::K_ERROR, tok_col, tok_len);
            return 1'b1;
          end
          extend();
          if (b == lts_pkg::CH_QUOTE) begin
            mode = SC_START;
            emit(lts_pkg::K_STRING, tok_col, tok_len);
          end
          return 1'b0;
        end
        SC_INT: begin
          if (is_num(b)) begin
            extend();
            return 1'b0;
          end
          if (b == lts_pkg::CH_DOT) begin
            extend();
            mode = SC_DOT;
            return 1'b0;
          end
          mode = SC_START;
          emit(lts_pkg::K_NUM, tok_col, tok_len);
          return 1'b1;
        end
        SC_DOT: begin
          if (is_num(b)) begin
            extend();
            mode = SC_FRAC;
            return 1'b0;
          end
          mode = SC_START;
          if (b == lts_pkg::CH_NL || b == lts_pkg::CH_EOF) begin
            emit(lts_pkg::K_ERROR, tok_col, tok_len);
            return 1'b1;
          end
          extend();
          emit(lts_pkg::K_ERROR, tok_col, tok_len);
          return 1'b0;
        end
        SC_FRAC: begin
          if (is_num(b)) begin
            extend();
            return 1'b0;
          end
          mode = SC_START;
          emit(lts_pkg::K_NUM, tok_col, tok_len);
          return 1'b1;
        end
        default: begin
          mode = SC_START;
          return 1'b1;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      fresh_q.delete();
      if (mode == SC_START || scan_inside(b)) scan_fresh(b);
      if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
      foreach (fresh_q[i]) want_q.push_back(fresh_q[i]);
    endfunction

    function void compare(string field_name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        n_errors++;
        $error("%s: expected %0d, got %0d", field_name, exp_val, got_val);
      end
    endfunction

    function void check_token(logic [47:0] data, logic last);
      lts_pkg::tok_t want;
      if (want_q.size() == 0) begin
        n_errors++;
        $error("token beat with nothing expected: %h", data);
        return;
      end
      want = want_q.pop_front();
      compare("token_kind", want.kind, data[4:0]);
      compare("token_line", want.line, data[20:5]);
      compare("token_column", want.column, data[36:21]);
      compare("token_length", want.length, data[44:37]);
      compare("last_of_run", want.last, last);
    endfunction

    function int unsigned outstanding();
      return want_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  token_scoreboard sb = new();
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     bytes_sent  = 0;
  bit              hold_req    = 1'b0;

  logic [7:0] warmup_bytes[$] = '{8'h00, lts_pkg::CH_EQ, lts_pkg::CH_EQ, lts_pkg::CH_LT, "x",
                                  lts_pkg::CH_BANG, lts_pkg::CH_EQ, lts_pkg::CH_GT,
                                  lts_pkg::CH_GT, lts_pkg::CH_EQ, lts_pkg::CH_QUOTE,
                                  lts_pkg::CH_NL, lts_pkg::CH_QUOTE, "1", lts_pkg::CH_DOT,
                                  "5", lts_pkg::CH_DOT, "z", lts_pkg::CH_DOT, lts_pkg::CH_NL,
                                  lts_pkg::CH_HASH, "q", lts_pkg::CH_EOF, lts_pkg::CH_QUOTE,
                                  lts_pkg::CH_EOF, lts_pkg::CH_DOT, lts_pkg::CH_EOF,
                                  lts_pkg::CH_PLUS, lts_pkg::CH_MINUS, lts_pkg::CH_STAR,
                                  lts_pkg::CH_SLASH, lts_pkg::CH_PCT, lts_pkg::CH_LPAR,
                                  lts_pkg::CH_RPAR, lts_pkg::CH_AMP, lts_pkg::CH_BAR,
                                  lts_pkg::CH_BANG, lts_pkg::CH_TAB, "9", lts_pkg::CH_EOF};

  lexical_token_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Input beats are noted before output beats are checked, so a same-edge pair stays ordered.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
    end
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [7:0] any_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? 8'h61 + r[7:0] : 8'h41 + r[7:0] - 8'd26;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_random_token();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_byte(any_letter());
      n = $urandom_range(10);
      repeat (n) send_byte(($urandom_range(2) == 0) ? any_digit() : any_letter());
    end else if (pick < 33) begin
      if ($urandom_range(4) == 0) begin
        send_byte(lts_pkg::CH_DOT);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(any_digit());
        if ($urandom_range(1) == 1) send_byte(lts_pkg::CH_DOT);
      end
      n = $urandom_range(4);
      repeat (n) send_byte(any_digit());
    end else if (pick < 43) begin
      send_byte(lts_pkg::CH_QUOTE);
      n = $urandom_range(12);
      repeat (n) begin
        c = 8'($urandom_range(32, 126));
        if (c == lts_pkg::CH_QUOTE) c = "a";
        if ($urandom_range(9) == 0) c = lts_pkg::CH_NL;
        send_byte(c);
      end
      if ($urandom_range(9) != 0) send_byte(lts_pkg::CH_QUOTE);
    end else if (pick < 61) begin
      send_byte(OP_CHARS[$urandom_range(12)]);
      if ($urandom_range(1) == 1) send_byte(lts_pkg::CH_EQ);
    end else if (pick < 71) begin
      send_byte(($urandom_range(1) == 1) ? lts_pkg::CH_SP : lts_pkg::CH_TAB);
    end else if (pick < 79) begin
      send_byte(lts_pkg::CH_NL);
    end else if (pick < 84) begin
      send_byte(lts_pkg::CH_HASH);
      n = $urandom_range(8);
      repeat (n) begin
        c = 8'($urandom_range(254));
        send_byte((c == lts_pkg::CH_NL) ? lts_pkg::CH_SP : c);
      end
      send_byte(lts_pkg::CH_NL);
    end else if (pick < 87) begin
      send_byte(lts_pkg::CH_EOF);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(9) < 4) send_byte(lts_pkg::CH_SP);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 17;
    rx_idle_pct = 71;
    foreach (warmup_bytes[i]) send_byte(warmup_bytes[i]);
    while (bytes_sent < 300) send_random_token();

    tx_idle_pct = 71;
    rx_idle_pct = 17;
    while (bytes_sent < 600) send_random_token();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    while (bytes_sent < 900) send_random_token();

    // An over-long string whose length saturates, then a short closing sequence.
    send_byte(lts_pkg::CH_EOF);
    send_byte(lts_pkg::CH_NL);
    send_byte(lts_pkg::CH_QUOTE);
    repeat (LONG_STR) send_byte("s");
    send_byte(lts_pkg::CH_QUOTE);
    send_byte(lts_pkg::CH_PLUS);
    send_byte(lts_pkg::CH_NL);
    send_byte("k");
    send_byte(lts_pkg::CH_NL);
    send_byte(lts_pkg::CH_LPAR);
    send_byte(lts_pkg::CH_EOF);
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lts_pkg.sv
sv/lts_scan.sv
sv/lts_tokq.sv
sv/lexical_token_scanner.sv
sv/lts_checker.sv
tb/tb_top.sv
